[src/tpc_pkg.sv]
// Package: shared types and constants for the trinomial power block.
`timescale 1ns / 1ps
package tpc_pkg;

    localparam int COEF_W = 33;
    localparam int EXP_W  = 5;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx REG_COEF_LIMIT   = 2'd0;
    localparam t_cfg_idx REG_DEGREE_LIMIT = 2'd1;

    localparam logic STATUS_VALID   = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_CALC,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

endpackage

[src/tpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tpc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/trinomial_power_coefficients.sv]
// Top level: expands (a*x^2 + b*x + c)^d into 2d+1 exact coefficients.
// An invalid request yields its error result through the error state and the output register.
// A valid request runs d multiply passes, pass p computing 2p+1 coefficients,
// then emits the coefficients one by one, each by a RAM read and then an output register load.
// A new request is taken only in idle, once the last result item has been loaded.
// Reset (synchronous, active low) clears control and config; the coefficient RAM is not swept.
`timescale 1ns / 1ps
module trinomial_power_coefficients
    import tpc_pkg::*;
#(
    parameter int MAX_DEGREE = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wen,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [3:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // quad_coef[3:0], lin_coef[7:4], const_coef[11:8],
                                       // power_deg[15:12]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // exponent[4:0], coefficient[37:5], zero pad[39:38]
    output logic        m_axis_tuser,  // status[0]
    output logic        m_axis_tlast
);

    localparam int DEPTH = 2 * MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [3:0] MAX_DEG4 = 4'(MAX_DEGREE);

    function automatic logic [3:0] f_mag(input logic signed [3:0] v);
        return v[3] ? 4'(-v) : 4'(v);
    endfunction

    t_state r_state, n_state;

    logic [1:0] r_coef_lim;
    logic [3:0] r_deg_lim;

    logic signed [3:0] r_a, r_b, r_c;
    logic [3:0]        r_d;
    logic [3:0]        r_pass, n_pass;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_e, n_e;

    logic          r_s1_vld, r_s1_first, r_s1_init, r_s1_rd;
    logic [AW-1:0] r_s1_k;
    logic          n_s1_vld, n_s1_first, n_s1_init, n_s1_rd;
    t_coef         r_w0, r_w1;

    logic             r_out_vld, n_out_vld;
    logic [EXP_W-1:0] r_out_exp, n_out_exp;
    t_coef            r_out_coef, n_out_coef;
    logic             r_out_stat, n_out_stat;
    logic             r_out_last, n_out_last;
    logic             out_load;

    logic              in_fire, out_free, req_ok;
    logic signed [3:0] in_a, in_b, in_c;
    logic [3:0]        in_d, dlim, lim4;

    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [COEF_W-1:0] ram_rdata;

    t_coef                    v_new, t0, t1, rd_coef;
    logic signed [COEF_W+3:0] p_a, p_b, p_c;
    logic signed [COEF_W+5:0] mac_sum;

    assign in_a = s_axis_tdata[3:0];
    assign in_b = s_axis_tdata[7:4];
    assign in_c = s_axis_tdata[11:8];
    assign in_d = s_axis_tdata[15:12];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    assign lim4   = {2'b00, r_coef_lim};
    assign dlim   = (r_deg_lim > MAX_DEG4) ? MAX_DEG4 : r_deg_lim;
    assign req_ok = (in_a != 4'sd0) && (f_mag(in_a) <= lim4) && (f_mag(in_b) <= lim4)
                    && (f_mag(in_c) <= lim4) && (in_d != 4'd0) && (in_d <= dlim);

    // multiply stage: new[k] = c*s[k] + b*s[k-1] + a*s[k-2]
    assign rd_coef = $signed(ram_rdata);
    assign v_new   = !r_s1_rd ? '0 : (r_s1_init ? t_coef'(1) : rd_coef);
    assign t1      = r_s1_first ? '0 : r_w1;
    assign t0      = r_s1_first ? '0 : r_w0;
    assign p_c     = r_c * t1;
    assign p_b     = r_b * t0;
    assign p_a     = r_a * v_new;
    assign mac_sum = (COEF_W+6)'(p_c) + (COEF_W+6)'(p_b) + (COEF_W+6)'(p_a);

    tpc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_k),
        .i_wdata (mac_sum[COEF_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        n_k        = r_k;
        n_e        = r_e;
        n_s1_vld   = 1'b0;
        n_s1_first = 1'b0;
        n_s1_init  = 1'b0;
        n_s1_rd    = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_e;
        out_load   = 1'b0;
        n_out_exp  = r_out_exp;
        n_out_coef = r_out_coef;
        n_out_stat = r_out_stat;
        n_out_last = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (req_ok) begin
                        n_pass  = 4'd1;
                        n_k     = AW'(2);
                        n_state = S_CALC;
                    end else begin
                        n_pass  = 4'd0;
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_exp  = '0;
                    n_out_coef = '0;
                    n_out_stat = STATUS_INVALID;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CALC: begin
                n_s1_vld   = 1'b1;
                n_s1_first = (r_k == AW'({r_pass, 1'b0}));
                n_s1_init  = (r_pass == 4'd1);
                n_s1_rd    = (r_k >= AW'(2));
                ram_re     = n_s1_rd;
                ram_raddr  = r_k - AW'(2);
                if (r_k == '0) begin
                    if (r_pass == r_d) begin
                        n_e     = AW'({r_d, 1'b0});
                        n_state = S_EMIT_RD;
                    end else begin
                        n_pass = r_pass + 4'd1;
                        n_k    = AW'({n_pass, 1'b0});
                    end
                end else begin
                    n_k = r_k - AW'(1);
                end
            end
            S_EMIT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_e;
                n_state   = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_exp  = EXP_W'(r_e);
                    n_out_coef = rd_coef;
                    n_out_stat = STATUS_VALID;
                    n_out_last = (r_e == '0);
                    if (r_e == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e - AW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_vld = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass     <= 4'd0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_coef_lim <= 2'd3;
            r_deg_lim  <= 4'd10;
        end else begin
            r_state   <= n_state;
            r_pass    <= n_pass;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    REG_COEF_LIMIT:   r_coef_lim <= i_cfg_wdata[1:0];
                    REG_DEGREE_LIMIT: r_deg_lim  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= in_a;
            r_b <= in_b;
            r_c <= in_c;
            r_d <= in_d;
        end
        r_k        <= n_k;
        r_e        <= n_e;
        r_s1_first <= n_s1_first;
        r_s1_init  <= n_s1_init;
        r_s1_rd    <= n_s1_rd;
        r_s1_k     <= r_k;
        if (r_s1_vld) begin
            r_w1 <= t0;
            r_w0 <= v_new;
        end
        r_out_exp  <= n_out_exp;
        r_out_coef <= n_out_coef;
        r_out_stat <= n_out_stat;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_coef, r_out_exp};
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tlast  = r_out_last;

endmodule

[src/tpc_checker.sv]
// Checker: port-level assertions for the trinomial power block, bound to the top level.
`timescale 1ns / 1ps
module tpc_checker
    import tpc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic             r_in_frame;
    logic [EXP_W-1:0] r_prev_exp;
    logic             m_fire;
    logic [EXP_W-1:0] m_exp;

    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign m_exp  = m_axis_tdata[EXP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (m_fire) begin
            r_in_frame <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_fire) begin
            r_prev_exp <= m_exp;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_INVALID)
        |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("error result is not a lone zero item");

    a_exp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && r_in_frame) |-> (m_exp == EXP_W'(r_prev_exp - 5'd1)))
        else $error("exponent does not step down by one");

    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_VALID && m_axis_tlast) |-> (m_exp == '0))
        else $error("last coefficient not at exponent zero");

endmodule

bind trinomial_power_coefficients tpc_checker u_tpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
